### rtl/tlfs_pkg.sv
// Shared types and constants for the type-length frame splitter.
// No dependencies; every other file of the block depends on this package.
`timescale 1ns / 1ps
`default_nettype none

package tlfs_pkg;

   // Number of message types, each with its own unit size register.
   localparam int NUM_TYPES = 5;

   // Field widths.
   localparam int BYTE_W   = 8;
   localparam int TYPE_W   = 3;
   localparam int COUNT_W  = 4;
   localparam int STATUS_W = 2;
   localparam int LEFT_W   = 12;
   localparam int CSR_IDX_W = 3;

   // Framing constants.
   localparam logic [BYTE_W-1:0] START_BYTE     = 8'h02;
   localparam logic [LEFT_W-1:0] FRAME_OVERHEAD = 12'd4;
   // Start and header bytes are already behind us when the body length is set.
   localparam logic [LEFT_W-1:0] HEAD_BYTES     = 12'd2;
   localparam logic [TYPE_W-1:0] TYPE_MIN       = 3'd1;
   localparam logic [TYPE_W-1:0] TYPE_MAX       = 3'd5;

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_UNIT_SIZE_TYPE1 = 3'd0,
      CSR_UNIT_SIZE_TYPE2 = 3'd1,
      CSR_UNIT_SIZE_TYPE3 = 3'd2,
      CSR_UNIT_SIZE_TYPE4 = 3'd3,
      CSR_UNIT_SIZE_TYPE5 = 3'd4
   } csr_index_type;

   // Reset values of the unit size registers.
   localparam logic [BYTE_W-1:0] UNIT_SIZE_RESET [NUM_TYPES] =
      '{8'd32, 8'd128, 8'd12, 8'd208, 8'd224};

   // All unit sizes, as handed from the register file to the parser.
   typedef logic [NUM_TYPES-1:0][BYTE_W-1:0] unit_sizes_type;

   // Parser phase.
   typedef enum logic [1:0] {
      PH_HUNT   = 2'd0,
      PH_HEADER = 2'd1,
      PH_BODY   = 2'd2,
      PH_AFTER  = 2'd3
   } phase_type;

   // Classification of each byte.
   typedef enum logic [STATUS_W-1:0] {
      ST_OUTSIDE = 2'd0,
      ST_FRAME   = 2'd1,
      ST_LAST    = 2'd2,
      ST_ERROR   = 2'd3
   } status_type;

   // One result beat.
   typedef struct packed {
      status_type               status;
      logic [TYPE_W-1:0]        msg_type;
      logic [COUNT_W-1:0]       msg_count;
   } result_type;

   // Hand-off from the input stage to the parser.
   typedef struct packed {
      logic              valid;
      logic [BYTE_W-1:0] data;
   } item_type;

endpackage

`default_nettype wire

### rtl/tlfs_if.sv
// Valid/ready channel interfaces for the type-length frame splitter.
// Depends on tlfs_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

// Input byte stream.
interface tlfs_req_if;
   logic                      valid;
   logic                      ready;
   logic [tlfs_pkg::BYTE_W-1:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

// Per-byte classification results.
interface tlfs_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [tlfs_pkg::STATUS_W-1:0] status;
   logic [tlfs_pkg::TYPE_W-1:0]   msg_type;
   logic [tlfs_pkg::COUNT_W-1:0]  msg_count;

   modport source (output valid, output status, output msg_type, output msg_count,
                   input ready);
   modport sink   (input valid, input status, input msg_type, input msg_count,
                   output ready);
endinterface

// Configuration register writes.
interface tlfs_csr_if;
   logic                           valid;
   logic                           ready;
   logic [tlfs_pkg::CSR_IDX_W-1:0] index;
   logic [tlfs_pkg::BYTE_W-1:0]    data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### rtl/tlfs_csr_regs.sv
// Unit size configuration registers of the type-length frame splitter.
// Depends on tlfs_pkg and the tlfs_csr_if interface.
`timescale 1ns / 1ps
`default_nettype none

module tlfs_csr_regs (
   input  logic                     clock,
   input  logic                     reset,
   tlfs_csr_if.sink                 csr_chan,
   output tlfs_pkg::unit_sizes_type unit_sizes
);
   import tlfs_pkg::*;

   unit_sizes_type unit_sizes_ff;
   unit_sizes_type unit_sizes_in;
   logic           write_beat;

   // Writes are always taken at once.
   assign csr_chan.ready = 1'b1;
   assign write_beat     = csr_chan.valid & csr_chan.ready;

   // Decode the register index; indexes beyond the list are ignored.
   always_comb begin
      unit_sizes_in = unit_sizes_ff;
      if (write_beat) begin
         unique case (csr_chan.index)
            CSR_UNIT_SIZE_TYPE1: unit_sizes_in[0] = csr_chan.data;
            CSR_UNIT_SIZE_TYPE2: unit_sizes_in[1] = csr_chan.data;
            CSR_UNIT_SIZE_TYPE3: unit_sizes_in[2] = csr_chan.data;
            CSR_UNIT_SIZE_TYPE4: unit_sizes_in[3] = csr_chan.data;
            CSR_UNIT_SIZE_TYPE5: unit_sizes_in[4] = csr_chan.data;
            default:             unit_sizes_in = unit_sizes_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_TYPES; i++) begin
            unit_sizes_ff[i] <= UNIT_SIZE_RESET[i];
         end
      end else begin
         unit_sizes_ff <= unit_sizes_in;
      end
   end

   assign unit_sizes = unit_sizes_ff;

endmodule

`default_nettype wire

### rtl/tlfs_in_stage.sv
// Input register of the type-length frame splitter: captures one byte beat.
// Depends on tlfs_pkg and the tlfs_req_if interface.
`timescale 1ns / 1ps
`default_nettype none

module tlfs_in_stage (
   input  logic               clock,
   input  logic               reset,
   tlfs_req_if.sink           req_chan,
   input  logic               advance,
   output tlfs_pkg::item_type item
);
   import tlfs_pkg::*;

   logic              valid_ff;
   logic              valid_in;
   logic [BYTE_W-1:0] byte_ff;
   logic              accept;

   // The register can take a new beat when empty or when its byte moves on.
   assign req_chan.ready = ~valid_ff | advance;
   assign accept         = req_chan.valid & req_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload needs no reset.
   always_ff @(posedge clock) begin
      if (accept) begin
         byte_ff <= req_chan.data_byte;
      end
   end

   assign item.valid = valid_ff;
   assign item.data  = byte_ff;

endmodule

`default_nettype wire

### rtl/tlfs_parser.sv
// Frame parser of the type-length frame splitter: phase state machine,
// frame length counter and result register. Depends on tlfs_pkg and tlfs_rsp_if.
`timescale 1ns / 1ps
`default_nettype none

module tlfs_parser (
   input  logic                     clock,
   input  logic                     reset,
   input  tlfs_pkg::item_type       item,
   input  tlfs_pkg::unit_sizes_type unit_sizes,
   output logic                     advance,
   tlfs_rsp_if.source               rsp_chan
);
   import tlfs_pkg::*;

   phase_type          phase_ff,       phase_in;
   logic [LEFT_W-1:0]  bytes_left_ff,  bytes_left_in;
   logic [TYPE_W-1:0]  frame_type_ff,  frame_type_in;
   logic [COUNT_W-1:0] frame_count_ff, frame_count_in;
   logic               rsp_valid_ff,   rsp_valid_in;
   result_type         result_ff,      result_in;

   logic [BYTE_W-1:0]  hdr_type_raw;
   logic [TYPE_W-1:0]  hdr_type;
   logic [COUNT_W-1:0] hdr_count;
   logic               hdr_ok;
   logic [BYTE_W-1:0]  unit_size;
   logic [LEFT_W-1:0]  body_left;

   // A byte moves into the result register when that register is free.
   assign advance = item.valid & (~rsp_valid_ff | rsp_chan.ready);

   // Header fields: type in the low nibble, count in the high nibble.
   assign hdr_type_raw = {{(BYTE_W-COUNT_W){1'b0}}, item.data[COUNT_W-1:0]};
   assign hdr_type     = hdr_type_raw[TYPE_W-1:0];
   assign hdr_count    = item.data[BYTE_W-1:COUNT_W];
   assign hdr_ok       = (hdr_type_raw >= BYTE_W'(TYPE_MIN))
                       & (hdr_type_raw <= BYTE_W'(TYPE_MAX))
                       & (hdr_count != '0);

   // Unit size for the header's type.
   always_comb begin
      case (hdr_type)
         3'd1:    unit_size = unit_sizes[0];
         3'd2:    unit_size = unit_sizes[1];
         3'd3:    unit_size = unit_sizes[2];
         3'd4:    unit_size = unit_sizes[3];
         3'd5:    unit_size = unit_sizes[4];
         default: unit_size = '0;
      endcase
   end

   // Bytes still to come after the header: size * count + overhead - 2.
   assign body_left = (LEFT_W'(unit_size) * LEFT_W'(hdr_count))
                    + (FRAME_OVERHEAD - HEAD_BYTES);

   // Next state and result for the byte in the input register.
   always_comb begin
      phase_in       = phase_ff;
      bytes_left_in  = bytes_left_ff;
      frame_type_in  = frame_type_ff;
      frame_count_in = frame_count_ff;
      result_in      = result_ff;
      rsp_valid_in   = rsp_valid_ff & ~rsp_chan.ready;

      if (advance) begin
         rsp_valid_in = 1'b1;
         unique case (phase_ff)
            PH_HUNT, PH_AFTER: begin
               if (item.data == START_BYTE) begin
                  phase_in       = PH_HEADER;
                  frame_type_in  = '0;
                  frame_count_in = '0;
                  result_in      = '{ST_FRAME, '0, '0};
               end else if (phase_ff == PH_AFTER) begin
                  // A frame must be followed straight away by a start byte.
                  phase_in  = PH_HUNT;
                  result_in = '{ST_ERROR, '0, '0};
               end else begin
                  result_in = '{ST_OUTSIDE, '0, '0};
               end
            end
            PH_HEADER: begin
               if (hdr_ok) begin
                  phase_in       = PH_BODY;
                  frame_type_in  = hdr_type;
                  frame_count_in = hdr_count;
                  bytes_left_in  = body_left;
                  result_in      = '{ST_FRAME, hdr_type, hdr_count};
               end else begin
                  phase_in       = PH_HUNT;
                  frame_type_in  = '0;
                  frame_count_in = '0;
                  bytes_left_in  = '0;
                  result_in      = '{ST_ERROR, '0, '0};
               end
            end
            PH_BODY: begin
               // An already empty remainder also closes the frame.
               if (bytes_left_ff <= LEFT_W'(1)) begin
                  phase_in      = PH_AFTER;
                  bytes_left_in = '0;
                  result_in     = '{ST_LAST, frame_type_ff, frame_count_ff};
               end else begin
                  bytes_left_in = bytes_left_ff - LEFT_W'(1);
                  result_in     = '{ST_FRAME, frame_type_ff, frame_count_ff};
               end
            end
            default: phase_in = PH_HUNT;
         endcase
      end
   end

   // Control and frame state.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_HUNT;
         bytes_left_ff  <= '0;
         frame_type_ff  <= '0;
         frame_count_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         bytes_left_ff  <= bytes_left_in;
         frame_type_ff  <= frame_type_in;
         frame_count_ff <= frame_count_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Result payload needs no reset.
   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.status    = result_ff.status;
   assign rsp_chan.msg_type  = result_ff.msg_type;
   assign rsp_chan.msg_count = result_ff.msg_count;

endmodule

`default_nettype wire

### rtl/type_length_frame_splitter.sv
// Top level of the type-length frame splitter.
// Depends on tlfs_pkg, the channel interfaces, tlfs_csr_regs, tlfs_in_stage, tlfs_parser.
//
// req_chan carries the received stream, one byte per beat (data_byte). rsp_chan
// returns exactly one result beat per byte, in order: status (outside frame, frame
// byte, last byte of frame, error) and the frame's type and count once its header
// has been seen. csr_chan writes the five unit size registers (index 0 to 4 for
// types 1 to 5; other indexes are ignored). Writes are taken at once and are meant
// to be made while no byte is in flight. A frame is a start byte 0x02, a header
// byte (type low nibble, count high nibble) and further bytes up to
// unit_size * count + 4 bytes in all.
// A byte accepted from req_chan is held in the input register and then moves on
// into the result register, which rsp_chan shows. One byte per cycle is sustained
// while rsp_chan.ready stays high; the 8 by 4 bit multiply and add for the frame
// length sets the clock. Synchronous reset empties both registers, restores the unit
// sizes and puts the parser into hunting for a start byte. While the receiver holds
// rsp_chan.ready low the result stays put, the input register takes at most one
// more byte, and req_chan.ready stays low for as long as that register is full.
`timescale 1ns / 1ps
`default_nettype none

module type_length_frame_splitter (
   input  logic        clock,
   input  logic        reset,
   tlfs_req_if.sink    req_chan,
   tlfs_rsp_if.source  rsp_chan,
   tlfs_csr_if.sink    csr_chan
);
   import tlfs_pkg::*;

   unit_sizes_type unit_sizes;
   item_type       item;
   logic           advance;

   // Configuration registers.
   tlfs_csr_regs u_csr_regs (
      .clock      (clock),
      .reset      (reset),
      .csr_chan   (csr_chan),
      .unit_sizes (unit_sizes)
   );

   // Input register.
   tlfs_in_stage u_in_stage (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .advance  (advance),
      .item     (item)
   );

   // Parser and result register.
   tlfs_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .item       (item),
      .unit_sizes (unit_sizes),
      .advance    (advance),
      .rsp_chan   (rsp_chan)
   );

endmodule

`default_nettype wire
